// File: sv/sha512_hasher_macros.svh
// assertion helpers for the hasher checker
`ifndef SHA512_HASHER_MACROS_SVH
`define SHA512_HASHER_MACROS_SVH

`define SHA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: sv/sha_pkg.sv
`default_nettype none
package sha_pkg;

    typedef logic [63:0] word_t;

    localparam word_t INIT_H [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam word_t ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [6:0] PAD_LEN_POS = 7'd112;
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    function automatic word_t ror(input word_t v, input int unsigned n);
        ror = (v >> n) | (v << (64 - n));
    endfunction

endpackage
`default_nettype wire

// File: sv/sha_core.sv
`default_nettype none
// 80-round compression; schedule in a 16-entry ring, hash words in a memory
module sha_core
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // block buffer write side
    input  wire logic        wr_en,
    input  wire logic [3:0]  wr_addr,
    input  wire word_t       wr_data,
    input  wire logic        start,
    output logic             busy,
    // digest read / reinit
    input  wire logic [2:0]  h_raddr,
    output word_t            h_rdata,
    input  wire logic        h_reinit
);
    word_t w_mem [16];
    word_t h_mem [8];
    word_t v_reg [8];
    word_t h_rd_reg;

    // phases: 0 idle, 1 load h, 2 rounds, 3 fold back
    localparam logic [1:0] PH_IDLE = 2'd0, PH_LOAD = 2'd1, PH_RND = 2'd2, PH_FOLD = 2'd3;
    logic [1:0] phase_reg;
    logic [6:0] cnt_reg;
    logic [3:0] h_cnt_reg;
    logic [3:0] init_cnt_reg;

    word_t wt, s0, s1, t1, t2, big0, big1, ch, mj;
    word_t w15, w2, w16, w7;
    logic [3:0] ri;

    assign ri  = cnt_reg[3:0];
    assign w16 = w_mem[ri];
    assign w15 = w_mem[ri + 4'd1];
    assign w7  = w_mem[ri + 4'd9];
    assign w2  = w_mem[ri + 4'd14];

    always_comb
    begin
        s0 = ror(w15, 1) ^ ror(w15, 8) ^ (w15 >> 7);
        s1 = ror(w2, 19) ^ ror(w2, 61) ^ (w2 >> 6);
        wt = (cnt_reg < 7'd16) ? w16 : (w16 + s0 + w7 + s1);
        big1 = ror(v_reg[4], 14) ^ ror(v_reg[4], 18) ^ ror(v_reg[4], 41);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch + ROUND_K[cnt_reg] + wt;
        big0 = ror(v_reg[0], 28) ^ ror(v_reg[0], 34) ^ ror(v_reg[0], 39);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + mj;
    end

    assign busy = (phase_reg != PH_IDLE) || (init_cnt_reg != 4'd8);

    // schedule ring memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            w_mem[wr_addr] <= wr_data;
        else if (phase_reg == PH_RND && cnt_reg >= 7'd16)
            w_mem[ri] <= wt;
    end

    // hash word memory: registered read
    always_ff @(posedge clk)
    begin
        h_rd_reg <= h_mem[h_raddr];
        if (init_cnt_reg != 4'd8)
            h_mem[init_cnt_reg[2:0]] <= INIT_H[init_cnt_reg[2:0]];
        else if (phase_reg == PH_FOLD)
            h_mem[h_cnt_reg[2:0]] <= h_mem[h_cnt_reg[2:0]] + v_reg[h_cnt_reg[2:0]];
    end
    assign h_rdata = h_rd_reg;

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_LOAD)
            v_reg[h_cnt_reg[2:0]] <= h_mem[h_cnt_reg[2:0]];
        else if (phase_reg == PH_RND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cnt_reg      <= '0;
            h_cnt_reg    <= '0;
            init_cnt_reg <= '0;
        end
        else
        begin
            if (h_reinit)
                init_cnt_reg <= '0;
            else if (init_cnt_reg != 4'd8)
                init_cnt_reg <= init_cnt_reg + 4'd1;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_LOAD;
                        h_cnt_reg <= '0;
                    end
                end
                PH_LOAD:
                begin
                    if (h_cnt_reg == 4'd7)
                    begin
                        phase_reg <= PH_RND;
                        cnt_reg   <= '0;
                    end
                    h_cnt_reg <= h_cnt_reg + 4'd1;
                end
                PH_RND:
                begin
                    if (cnt_reg == 7'd79)
                    begin
                        phase_reg <= PH_FOLD;
                        h_cnt_reg <= '0;
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                end
                PH_FOLD:
                begin
                    if (h_cnt_reg == 4'd7)
                        phase_reg <= PH_IDLE;
                    h_cnt_reg <= h_cnt_reg + 4'd1;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/sha512_hasher.sv
// sha-512 streaming hasher, one message byte per input beat
// input: one beat per cycle while gathering a block; a full block stalls input while it is hashed
// (8 load + 80 rounds + 8 fold, all through the hash-word memory and schedule ring)
// end of message: the digest follows the last padding block, n bytes in the end block; one more
// block is hashed when n >= 112 and one when the end byte fills a block; each word is read before its beat
// reset: asynchronous, active low; hash memory then reloads its initial values while busy is held
`default_nettype none
module sha512_hasher
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // byte_present
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_number
    output logic             m_axis_tlast    // last_word
);
    // controller states
    localparam logic [2:0] ST_IN = 3'd0, ST_PAD = 3'd1, ST_WAIT = 3'd2,
                           ST_RD = 3'd3, ST_OUT = 3'd4, ST_HOLD = 3'd5;

    logic [2:0]  state_reg;
    logic [6:0]  pos_reg;
    logic [63:0] bits_reg, len_reg;
    word_t       acc_reg;         // word under assembly
    logic        pad_end_reg;     // padding done after current block
    logic [2:0]  wn_reg;
    logic        ovalid_reg;
    word_t       odata_reg;

    logic        busy, start, wr_en;
    logic        push;
    logic [7:0]  push_byte;
    word_t       acc_next;
    word_t       h_rdata;
    logic        accept_in;

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IN) && !busy;

    // byte source: input bytes, then padding: 0x80 first, zeros, then big-endian length
    always_comb
    begin
        push = 1'b0;
        push_byte = 8'h00;
        if (state_reg == ST_IN)
        begin
            push = accept_in && s_axis_tuser;
            push_byte = s_axis_tdata;
        end
        else if (state_reg == ST_HOLD && !busy)
        begin
            push = 1'b1;
            push_byte = PAD_BYTE;
        end
        else if (state_reg == ST_PAD && !busy)
        begin
            push = 1'b1;
            if (pos_reg >= 7'd120 && pad_end_reg)
                push_byte = len_reg[8'd63 - {pos_reg[2:0], 3'b000} -: 8];
            else
                push_byte = 8'h00;
        end
    end

    always_comb
    begin
        acc_next = (pos_reg[2:0] == 3'd0) ? 64'd0 : acc_reg;
        acc_next[8'd63 - {pos_reg[2:0], 3'b000} -: 8] = push_byte;
    end

    assign wr_en = push && (pos_reg[2:0] == 3'd7);
    assign start = push && (pos_reg == 7'd127);

    sha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (pos_reg[6:3]),
        .wr_data  (acc_next),
        .start    (start),
        .busy     (busy),
        .h_raddr  (wn_reg),
        .h_rdata  (h_rdata),
        .h_reinit (state_reg == ST_OUT && m_axis_tready && wn_reg == 3'd7)
    );

    always_ff @(posedge clk)
    begin
        if (push)
            acc_reg <= acc_next;
        if (state_reg == ST_RD)
            odata_reg <= h_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IN;
            pos_reg     <= '0;
            bits_reg    <= '0;
            len_reg     <= '0;
            pad_end_reg <= 1'b0;
            wn_reg      <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                pos_reg <= pos_reg + 7'd1;
            case (state_reg)
                ST_IN:
                begin
                    if (accept_in)
                    begin
                        if (s_axis_tlast)
                        begin
                            len_reg   <= bits_reg + (s_axis_tuser ? 64'd8 : 64'd0);
                            state_reg <= ST_HOLD;
                        end
                        else if (s_axis_tuser)
                            bits_reg <= bits_reg + 64'd8;
                    end
                end
                ST_HOLD:
                begin
                    // 0x80 marker byte goes in here; a marker in the last slot closes
                    // the block, so the length lands in the next one
                    if (!busy)
                    begin
                        state_reg <= ST_PAD;
                        pad_end_reg <= (pos_reg <= PAD_LEN_POS - 7'd1) ||
                                       (pos_reg == 7'd127);
                    end
                end
                ST_PAD:
                begin
                    if (push)
                    begin
                        if (pos_reg == 7'd127)
                        begin
                            if (pad_end_reg)
                                state_reg <= ST_WAIT;
                            else
                                pad_end_reg <= 1'b1;
                        end
                    end
                end
                ST_WAIT:
                begin
                    if (!busy)
                    begin
                        state_reg <= ST_RD;
                        wn_reg    <= '0;
                    end
                end
                ST_RD:
                begin
                    if (!ovalid_reg)
                        ovalid_reg <= 1'b1;
                    if (ovalid_reg)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        ovalid_reg <= 1'b0;
                        if (wn_reg == 3'd7)
                        begin
                            state_reg <= ST_IN;
                            bits_reg  <= '0;
                            pos_reg   <= '0;
                        end
                        else
                        begin
                            wn_reg    <= wn_reg + 3'd1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                default: state_reg <= ST_IN;
            endcase
        end
    end

    assign m_axis_tvalid = (state_reg == ST_OUT) && ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = wn_reg;
    assign m_axis_tlast  = (wn_reg == 3'd7);
endmodule
`default_nettype wire

// File: sv/sha512_hasher_checker.sv
`default_nettype none
`include "sha512_hasher_macros.svh"
module sha512_hasher_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    `SHA_ASSERT_IMPL(a_last_word, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 3'd7))
    `SHA_ASSERT_IMPL(a_no_overlap, m_axis_tvalid, !s_axis_tready)
    `SHA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tuser))
endmodule

bind sha512_hasher sha512_hasher_checker u_checker (.*);
`default_nettype wire
